>>> sv/ffrp_pkg.sv
// Shared types and constants for the FASTA/FASTQ record parser.
// Holds the channel word structs, result kinds and the front-to-back command format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffrp_pkg;

    localparam int MAX_HELD_SPACES = 8;
    localparam int HELD_IDX_W      = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
    localparam int HELD_CNT_W      = $clog2(MAX_HELD_SPACES + 1);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;

    typedef enum logic [2:0] {
        KIND_NAME  = 3'd0,
        KIND_SEQ   = 3'd1,
        KIND_QUAL  = 3'd2,
        KIND_END   = 3'd3,
        KIND_TRUNC = 3'd4,
        KIND_ERROR = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_HOLD  = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] item_kind;
        logic       last_of_run;
    } out_word_t;

    // count is the held-space count for a flush, or the store index for a hold.
    typedef struct packed {
        op_t                   op;
        logic [7:0]            data;
        kind_t                 kind;
        logic [HELD_CNT_W-1:0] count;
    } cmd_t;

endpackage

`default_nettype wire

>>> sv/ffrp_front.sv
// Front part of the record parser: accepts input words and updates the parse state.
// Emits one command per word that causes results. Depends on ffrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffrp_front
    import ffrp_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data,
    input  wire        q_full,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        PH_BEFORE     = 2'd0,
        PH_HEADER     = 2'd1,
        PH_LINE_START = 2'd2,
        PH_SEQ_LINE   = 2'd3
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [1:0]            line_idx_reg, line_idx_next;
    logic                  content_reg, content_next;
    logic                  open_reg, open_next;
    logic [HELD_CNT_W-1:0] count_reg, count_next;
    logic                  err_reg, err_next;
    logic                  format_reg;

    logic       accept;
    logic [7:0] c;
    logic       is_sp;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && !q_full;
    assign c         = s_data.text_byte;
    assign is_sp     = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);

    always_comb begin
        phase_next    = phase_reg;
        line_idx_next = line_idx_reg;
        content_next  = content_reg;
        open_next     = open_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        push          = 1'b0;
        cmd.op        = OP_EMIT;
        cmd.data      = c;
        cmd.kind      = KIND_SEQ;
        cmd.count     = count_reg;

        if (accept) begin
            if (s_data.end_of_file) begin
                if (!err_reg && open_reg) begin
                    push     = 1'b1;
                    cmd.data = 8'd0;
                    if (format_reg && !(line_idx_reg == 2'd3 && content_reg)) begin
                        cmd.kind = KIND_TRUNC;
                    end else begin
                        cmd.kind = KIND_END;
                    end
                end
                phase_next    = PH_BEFORE;
                line_idx_next = 2'd0;
                content_next  = 1'b0;
                open_next     = 1'b0;
                count_next    = '0;
                err_next      = 1'b0;
            end else if (!err_reg) begin
                if (!format_reg) begin
                    unique case (phase_reg)
                        PH_BEFORE: begin
                            if (c == CHAR_GT) begin
                                phase_next = PH_HEADER;
                                open_next  = 1'b1;
                            end else if (c != CHAR_NEWLINE) begin
                                err_next = 1'b1;
                                push     = 1'b1;
                                cmd.data = 8'd0;
                                cmd.kind = KIND_ERROR;
                            end
                        end
                        PH_HEADER: begin
                            if (c == CHAR_NEWLINE) begin
                                phase_next = PH_LINE_START;
                            end else begin
                                push     = 1'b1;
                                cmd.kind = KIND_NAME;
                            end
                        end
                        PH_LINE_START: begin
                            if (c == CHAR_GT) begin
                                push       = 1'b1;
                                cmd.data   = 8'd0;
                                cmd.kind   = KIND_END;
                                phase_next = PH_HEADER;
                                open_next  = 1'b1;
                            end else if (c != CHAR_NEWLINE) begin
                                // A fresh line holds nothing, so leading blanks vanish.
                                phase_next   = PH_SEQ_LINE;
                                count_next   = '0;
                                content_next = !is_sp;
                                push         = !is_sp;
                            end
                        end
                        PH_SEQ_LINE: begin
                            if (c == CHAR_NEWLINE) begin
                                phase_next   = PH_LINE_START;
                                content_next = 1'b0;
                                count_next   = '0;
                            end else if (is_sp) begin
                                if (content_reg &&
                                    count_reg < HELD_CNT_W'(MAX_HELD_SPACES)) begin
                                    push       = 1'b1;
                                    cmd.op     = OP_HOLD;
                                    count_next = count_reg + HELD_CNT_W'(1);
                                end
                            end else begin
                                push         = 1'b1;
                                cmd.op       = (count_reg != '0) ? OP_FLUSH : OP_EMIT;
                                count_next   = '0;
                                content_next = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_BEFORE;
                        end
                    endcase
                end else begin
                    open_next = 1'b1;
                    if (c == CHAR_NEWLINE) begin
                        content_next = 1'b0;
                        if (line_idx_reg == 2'd3) begin
                            push          = 1'b1;
                            cmd.data      = 8'd0;
                            cmd.kind      = KIND_END;
                            open_next     = 1'b0;
                            line_idx_next = 2'd0;
                        end else begin
                            line_idx_next = line_idx_reg + 2'd1;
                        end
                    end else begin
                        content_next = 1'b1;
                        unique case (line_idx_reg)
                            2'd0: begin
                                push     = 1'b1;
                                cmd.kind = KIND_NAME;
                            end
                            2'd1: begin
                                push     = 1'b1;
                                cmd.kind = KIND_SEQ;
                            end
                            2'd3: begin
                                push     = 1'b1;
                                cmd.kind = KIND_QUAL;
                            end
                            default: begin
                                push = 1'b0;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg   <= 1'b0;
            phase_reg    <= PH_BEFORE;
            line_idx_reg <= 2'd0;
            content_reg  <= 1'b0;
            open_reg     <= 1'b0;
            count_reg    <= '0;
            err_reg      <= 1'b0;
        end else if (cfg_valid) begin
            // A format change restarts parsing as at reset.
            format_reg   <= cfg_data;
            phase_reg    <= PH_BEFORE;
            line_idx_reg <= 2'd0;
            content_reg  <= 1'b0;
            open_reg     <= 1'b0;
            count_reg    <= '0;
            err_reg      <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            line_idx_reg <= line_idx_next;
            content_reg  <= content_next;
            open_reg     <= open_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/ffrp_queue.sv
// Short command queue between the parser front and the result back end.
// Register based FIFO with a combinational head. Depends on ffrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffrp_queue
    import ffrp_pkg::*;
(
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  wire   pop,
    output cmd_t  head,
    output logic  empty
);

    cmd_t                   entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] fill_reg;
    logic                   do_push, do_pop;

    assign full    = (fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/ffrp_back.sv
// Back end of the record parser: executes queued commands into result words.
// Keeps the held-whitespace store and the output register. Depends on ffrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffrp_back
    import ffrp_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  cmd_t       head,
    input  wire        empty,
    output logic       pop,
    output logic       m_valid,
    input  wire        m_ready,
    output out_word_t  m_data
);

    logic [7:0]            held_mem [MAX_HELD_SPACES];
    logic [HELD_CNT_W-1:0] flush_idx_reg;
    logic                  m_valid_reg;
    out_word_t             m_data_reg;
    logic                  slot_free;
    logic                  flushing_held;
    logic [7:0]            held_rd;

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign slot_free     = !m_valid_reg || m_ready;
    assign flushing_held = (head.op == OP_FLUSH) && (flush_idx_reg < head.count);
    assign held_rd       = held_mem[flush_idx_reg[HELD_IDX_W-1:0]];

    always_comb begin
        pop = 1'b0;
        if (!empty) begin
            unique case (head.op)
                OP_HOLD:  pop = 1'b1;
                OP_EMIT:  pop = slot_free;
                OP_FLUSH: pop = slot_free && !flushing_held;
                default:  pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!empty && head.op == OP_HOLD) begin
            held_mem[head.count[HELD_IDX_W-1:0]] <= head.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            flush_idx_reg <= '0;
        end else begin
            if (!empty && slot_free && head.op != OP_HOLD) begin
                m_valid_reg <= 1'b1;
                // Held spaces go out first, then the word that released them.
                if (flushing_held) begin
                    m_data_reg.out_byte    <= held_rd;
                    m_data_reg.item_kind   <= KIND_SEQ;
                    m_data_reg.last_of_run <= 1'b0;
                    flush_idx_reg          <= flush_idx_reg + HELD_CNT_W'(1);
                end else begin
                    m_data_reg.out_byte    <= head.data;
                    m_data_reg.item_kind   <= head.kind;
                    m_data_reg.last_of_run <= 1'b1;
                    flush_idx_reg          <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/fasta_fastq_record_parser_unit.sv
// FASTA/FASTQ record parser: splits a text byte stream into name, sequence and quality
// bytes with record-end marks. Top level; depends on ffrp_pkg, ffrp_front, ffrp_queue,
// ffrp_back.
//
// Usage: file bytes enter on the s_ channel (s_data.text_byte, or end_of_file set to
// close the open record and restart). Results leave on the m_ channel, one word per
// result, with last_of_run set on the final word caused by an input word. The cfg_
// channel writes file_format (0 FASTA, 1 FASTQ); cfg_ready is always high and a write
// restarts parsing. Write it only while the block is idle.
// Throughput: one input word per cycle while the four-entry command queue has room.
// A sequence byte that releases k held interior blanks puts k + 1 words out on the result
// side, which is what limits the sustained rate on whitespace-heavy lines.
// Path: an accepted input word is first written into the command queue; the back end
// then loads its result into the output register that drives m_valid.
// When m_ready is low, the output register holds its word, the queue fills and s_ready
// falls once it is full; nothing is lost. Synchronous active-low reset clears the parse
// state, the queue and the output valid; file_format resets to FASTA.
`timescale 1ns / 1ps
`default_nettype none

module fasta_fastq_record_parser_unit
    import ffrp_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_word_t  m_data,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t push_cmd, head_cmd;

    ffrp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (push_cmd)
    );

    ffrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    ffrp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head_cmd),
        .empty   (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
